// ===== rtl/core/madac_pkg.sv =====
package madac_pkg;

    // item commands
    localparam logic [1:0] CMD_DEFINE = 2'd0;
    localparam logic [1:0] CMD_BOUND  = 2'd1;
    localparam logic [1:0] CMD_INDEX  = 2'd2;

    localparam int ID_W   = 4;
    localparam int DIMS_W = 5;
    localparam int DSEL_W = 4;

    typedef struct packed {
        logic [1:0]         command;
        logic [ID_W-1:0]    array_id;
        logic [31:0]        base_address;
        logic [15:0]        element_bytes;
        logic [DIMS_W-1:0]  dim_count;
        logic [DSEL_W-1:0]  dim_select;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] index_value;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]    result_array;
        logic signed [63:0] physical_address;
    } result_t;

    // array header as held in the header memory
    typedef struct packed {
        logic [31:0]       base;
        logic [15:0]       size;
        logic [DIMS_W-1:0] dims;
    } hdr_t;

    // one dimension's limits as held in the bounds memory
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } bnd_t;

    // query launch from the decoder to the calculation sequencer
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [31:0]        sub;
    } launch_t;

endpackage

// ===== rtl/core/multi_dim_array_address_calc.sv =====
// row-major array address calculator
// input channel: an item (define header, set bounds, or one query subscript) is
// taken at a rising edge where start is high and busy is low
// define and bound transactions are written to the descriptor memories at that edge
// and never raise busy; a define is visible to a subscript taken the next cycle
// subscripts arrive in dimension order; each one reads the header and bounds
// memories, then folds into the running offset with three partial products on
// a shared 32x32 multiplier; busy stays high through ST_READ, ST_MUL0, ST_MUL1,
// ST_MUL2 and ST_ACC, so a subscript is taken only after the last has folded in
// the last subscript keeps busy through ST_SCL0, ST_SCL1 and ST_FIN for the
// element-size scaling and base add, and done is registered out of ST_FIN
// result: done is high for exactly one cycle with result valid; the receiver
// cannot stall and must take it in that cycle; the next item may be started
// in the same cycle the result shows
// reset clears the running offset and subscript position; descriptor memories
// are not cleared and must be defined before an array is queried
module multi_dim_array_address_calc #(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  madac_pkg::item_t   item,
    output logic               done,
    output madac_pkg::result_t result
);
    import madac_pkg::*;

    localparam int HAW = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int BDEPTH = MAX_ARRAYS * MAX_DIMS;
    localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int PW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic              accept;
    logic              id_ok;
    logic              dsel_ok;
    logic              hdr_we;
    logic              bnd_we;
    logic [HAW-1:0]    hdr_addr;
    logic [BAW-1:0]    bnd_waddr;
    logic [BAW-1:0]    bnd_raddr;
    logic [BAW-1:0]    row_base;
    logic [DIMS_W-1:0] dims_clamped;
    hdr_t              hdr_wdata;
    hdr_t              hdr_rdata;
    bnd_t              bnd_wdata;
    bnd_t              bnd_rdata;
    launch_t           launch;
    logic [PW-1:0]     pos;

    always_comb
    begin
        accept  = start & ~busy;
        id_ok   = {5'd0, item.array_id} < 9'(MAX_ARRAYS);
        dsel_ok = {3'd0, item.dim_select} < 7'(MAX_DIMS);

        if (item.dim_count == '0)
        begin
            dims_clamped = DIMS_W'(1);
        end
        else if (7'(item.dim_count) > 7'(MAX_DIMS))
        begin
            dims_clamped = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            dims_clamped = item.dim_count;
        end

        hdr_we   = accept & id_ok & (item.command == CMD_DEFINE);
        bnd_we   = accept & id_ok & dsel_ok & (item.command == CMD_BOUND);
        hdr_addr = HAW'(item.array_id);
        row_base = BAW'(item.array_id) * BAW'(MAX_DIMS);
        bnd_waddr = row_base + BAW'(item.dim_select);
        bnd_raddr = row_base + BAW'(pos);

        hdr_wdata.base = item.base_address;
        hdr_wdata.size = item.element_bytes;
        hdr_wdata.dims = dims_clamped;
        bnd_wdata.lo   = item.lower_bound;
        bnd_wdata.hi   = item.upper_bound;

        launch.valid = accept & id_ok & (item.command == CMD_INDEX);
        launch.id    = item.array_id;
        launch.sub   = item.index_value;
    end

    madac_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (MAX_ARRAYS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_addr),
        .wdata (hdr_wdata),
        .re    (launch.valid),
        .raddr (hdr_addr),
        .rdata (hdr_rdata)
    );

    madac_ram #(
        .WIDTH ($bits(bnd_t)),
        .DEPTH (BDEPTH)
    ) u_bnd_ram (
        .clk   (clk),
        .we    (bnd_we),
        .waddr (bnd_waddr),
        .wdata (bnd_wdata),
        .re    (launch.valid),
        .raddr (bnd_raddr),
        .rdata (bnd_rdata)
    );

    madac_calc #(
        .MAX_DIMS (MAX_DIMS)
    ) u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .hdr    (hdr_rdata),
        .bnd    (bnd_rdata),
        .pos    (pos),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule

// ===== rtl/core/madac_ram.sv =====
module madac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/madac_calc.sv =====
module madac_calc #(
    parameter int MAX_DIMS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  madac_pkg::launch_t                            launch,
    input  madac_pkg::hdr_t                               hdr,
    input  madac_pkg::bnd_t                               bnd,
    output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] pos,
    output logic                                          busy,
    output logic                                          done,
    output madac_pkg::result_t                            result
);
    import madac_pkg::*;

    localparam int PW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_READ = 9'b000000010,
        ST_MUL0 = 9'b000000100,
        ST_MUL1 = 9'b000001000,
        ST_MUL2 = 9'b000010000,
        ST_ACC  = 9'b000100000,
        ST_SCL0 = 9'b001000000,
        ST_SCL1 = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [63:0]       off_reg, off_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [ID_W-1:0]   id_reg, id_next;
    logic [31:0]       sub_reg, sub_next;
    logic [63:0]       ext_reg, ext_next;
    logic [63:0]       diff_reg, diff_next;
    logic [31:0]       base_reg, base_next;
    logic [15:0]       size_reg, size_next;
    logic              last_reg, last_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       mul_reg, mul_next;

    logic [31:0]       mul_a, mul_b;
    logic [33:0]       ext34;
    logic [32:0]       diff33;
    logic [DIMS_W-1:0] dims_eff;

    always_comb
    begin
        ext34    = {{2{bnd.hi[31]}}, bnd.hi} - {{2{bnd.lo[31]}}, bnd.lo} + 34'd1;
        diff33   = {sub_reg[31], sub_reg} - {bnd.lo[31], bnd.lo};
        dims_eff = (hdr.dims == '0) ? DIMS_W'(1) : hdr.dims;
    end

    // one shared 32x32 multiplier, partial products of the 64-bit wrap product
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL0:
            begin
                mul_a = off_reg[31:0];
                mul_b = ext_reg[31:0];
            end
            ST_MUL1:
            begin
                mul_a = off_reg[31:0];
                mul_b = ext_reg[63:32];
            end
            ST_MUL2:
            begin
                mul_a = off_reg[63:32];
                mul_b = ext_reg[31:0];
            end
            ST_SCL0:
            begin
                mul_a = off_reg[31:0];
                mul_b = {16'd0, size_reg};
            end
            ST_SCL1:
            begin
                mul_a = off_reg[63:32];
                mul_b = {16'd0, size_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_next = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        off_next    = off_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        id_next     = id_reg;
        sub_next    = sub_reg;
        ext_next    = ext_reg;
        diff_next   = diff_reg;
        base_next   = base_reg;
        size_next   = size_reg;
        last_next   = last_reg;
        acc_next    = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (launch.valid)
                begin
                    id_next    = launch.id;
                    sub_next   = launch.sub;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // memory data for the subscript's descriptor is here now
                ext_next   = {{30{ext34[33]}}, ext34};
                diff_next  = {{31{diff33[32]}}, diff33};
                base_next  = hdr.base;
                size_next  = hdr.size;
                last_next  = (7'(pos_reg) + 7'd1) >= 7'(dims_eff);
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                acc_next   = mul_reg + diff_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next[63:32] = acc_reg[63:32] + mul_reg[31:0];
                state_next      = ST_ACC;
            end
            ST_ACC:
            begin
                off_next = {acc_reg[63:32] + mul_reg[31:0], acc_reg[31:0]};
                if (last_reg)
                begin
                    state_next = ST_SCL0;
                end
                else
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_SCL0:
            begin
                state_next = ST_SCL1;
            end
            ST_SCL1:
            begin
                acc_next   = mul_reg + {32'd0, base_reg};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                result_next.result_array     = id_reg;
                result_next.physical_address = {acc_reg[63:32] + mul_reg[31:0],
                                                acc_reg[31:0]};
                done_next  = 1'b1;
                off_next   = '0;
                pos_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            off_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        id_reg     <= id_next;
        sub_reg    <= sub_next;
        ext_reg    <= ext_next;
        diff_reg   <= diff_next;
        base_reg   <= base_next;
        size_reg   <= size_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        mul_reg    <= mul_next;
    end

    assign pos    = pos_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
